// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the downscaler RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- rtl/nnd_pkg.sv -----
// Package for the nearest neighbor downscaler: payload and config types,
// register indexes, sizes and the saturating target step. No dependencies.
`timescale 1ns / 1ps

package nnd_pkg;

   localparam int MAX_WIDTH_DEF   = 4096;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int COMP_W     = 8;
   localparam int COORD_W    = 12;
   localparam int CNT_W      = 13;
   localparam int CFG_DIM_W  = 13;
   localparam int SCALE_W    = 29;
   localparam int TGT_W      = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = SCALE_W;

   localparam logic [TGT_W-1:0] TGT_MAX = {TGT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_SCALE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
      logic [COMP_W-1:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [COMP_W-1:0]  out_red;
      logic [COMP_W-1:0]  out_green;
      logic [COMP_W-1:0]  out_blue;
      logic [COMP_W-1:0]  out_alpha;
      logic [COORD_W-1:0] dst_col;
      logic [COORD_W-1:0] dst_row;
      logic               frame_end;
   } result_type;

   typedef struct packed {
      logic [CFG_DIM_W-1:0] src_width;
      logic [CFG_DIM_W-1:0] src_height;
      logic [CFG_DIM_W-1:0] dst_width;
      logic [CFG_DIM_W-1:0] dst_height;
      logic [SCALE_W-1:0]   scale_q16;
   } cfg_type;

   function automatic logic [TGT_W-1:0] advance(input logic [TGT_W-1:0] target,
                                                 input logic [SCALE_W-1:0] scale);
      logic [TGT_W:0] sum;
      sum = {1'b0, target} + (TGT_W+1)'(scale);
      if (sum > {1'b0, TGT_MAX}) begin
         return TGT_MAX;
      end
      return sum[TGT_W-1:0];
   endfunction

endpackage

// ----- rtl/nnd_front.sv -----
// Front end: accepts source pixels, tracks source position and fixed-point
// targets, and pushes selected pixels into the queue. Uses nnd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnd_front #(
   parameter int MAX_WIDTH  = nnd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = nnd_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = nnd_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nnd_pkg::cfg_type     cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  nnd_pkg::pixel_type   req_data,
   input  logic                 push_ready,
   output logic                 push_valid,
   output nnd_pkg::result_type  push_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int EXT_W = (POS_W + 1 > nnd_pkg::CFG_DIM_W) ? POS_W + 1 : nnd_pkg::CFG_DIM_W;
   localparam int INT_W = nnd_pkg::TGT_W - FRAC_BITS;
   localparam int CMP_W = (POS_W > INT_W) ? POS_W : INT_W;
   localparam int CNT_W = nnd_pkg::CNT_W;
   localparam int TGT_W = nnd_pkg::TGT_W;

   logic [COL_W-1:0] source_col_ff, source_col_in;
   logic [ROW_W-1:0] source_row_ff, source_row_in;
   logic [TGT_W-1:0] col_target_ff, col_target_in;
   logic [TGT_W-1:0] row_target_ff, row_target_in;
   logic [CNT_W-1:0] col_count_ff, col_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   logic [EXT_W-1:0] width_eff;
   logic [EXT_W-1:0] height_eff;
   logic             accept;
   logic             col_hit;
   logic             row_hit;
   logic             col_wrap;
   logic             row_wrap;

   always_comb begin
      if (cfg.src_width == '0) begin
         width_eff = EXT_W'(1);
      end else if (EXT_W'(cfg.src_width) > EXT_W'(MAX_WIDTH)) begin
         width_eff = EXT_W'(MAX_WIDTH);
      end else begin
         width_eff = EXT_W'(cfg.src_width);
      end
      if (cfg.src_height == '0) begin
         height_eff = EXT_W'(1);
      end else if (EXT_W'(cfg.src_height) > EXT_W'(MAX_HEIGHT)) begin
         height_eff = EXT_W'(MAX_HEIGHT);
      end else begin
         height_eff = EXT_W'(cfg.src_height);
      end
   end

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   assign col_hit = (col_count_ff < cfg.dst_width) &&
                    (CMP_W'(source_col_ff) == CMP_W'(col_target_ff[TGT_W-1:FRAC_BITS]));
   assign row_hit = (row_count_ff < cfg.dst_height) &&
                    (CMP_W'(source_row_ff) == CMP_W'(row_target_ff[TGT_W-1:FRAC_BITS]));
   assign col_wrap = (EXT_W'(source_col_ff) + EXT_W'(1)) >= width_eff;
   assign row_wrap = (EXT_W'(source_row_ff) + EXT_W'(1)) >= height_eff;

   assign push_valid = accept && col_hit && row_hit;

   always_comb begin
      push_data.out_red   = req_data.red;
      push_data.out_green = req_data.green;
      push_data.out_blue  = req_data.blue;
      push_data.out_alpha = req_data.alpha;
      push_data.dst_col   = col_count_ff[nnd_pkg::COORD_W-1:0];
      push_data.dst_row   = row_count_ff[nnd_pkg::COORD_W-1:0];
      push_data.frame_end =
         ((CNT_W+1)'(col_count_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(cfg.dst_width)) &&
         ((CNT_W+1)'(row_count_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(cfg.dst_height));
   end

   always_comb begin
      source_col_in = source_col_ff;
      source_row_in = source_row_ff;
      col_target_in = col_target_ff;
      row_target_in = row_target_ff;
      col_count_in  = col_count_ff;
      row_count_in  = row_count_ff;
      if (accept) begin
         if (col_hit) begin
            col_count_in  = col_count_ff + CNT_W'(1);
            col_target_in = nnd_pkg::advance(col_target_ff, cfg.scale_q16);
         end
         if (col_wrap) begin
            source_col_in = '0;
            col_count_in  = '0;
            col_target_in = '0;
            if (row_hit) begin
               row_count_in  = row_count_ff + CNT_W'(1);
               row_target_in = nnd_pkg::advance(row_target_ff, cfg.scale_q16);
            end
            if (row_wrap) begin
               source_row_in = '0;
               row_count_in  = '0;
               row_target_in = '0;
            end else begin
               source_row_in = source_row_ff + ROW_W'(1);
            end
         end else begin
            source_col_in = source_col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_col_ff <= '0;
         source_row_ff <= '0;
         col_target_ff <= '0;
         row_target_ff <= '0;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
      end else begin
         source_col_ff <= source_col_in;
         source_row_ff <= source_row_in;
         col_target_ff <= col_target_in;
         row_target_ff <= row_target_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
      end
   end

   `ASSERT_PROP(a_frame_wrap_clears, clock, reset, accept && col_wrap && row_wrap |=> source_col_ff == '0 && source_row_ff == '0 && row_count_ff == '0 && row_target_ff == '0)
   `ASSERT_PROP(a_col_count_steps, clock, reset, accept && col_hit && !col_wrap |=> col_count_ff == $past(col_count_ff) + CNT_W'(1))

endmodule

// ----- rtl/nnd_queue.sv -----
// Short result queue between front and back end, register slots with
// read and write pointers. Uses nnd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnd_queue #(
   parameter int DEPTH = nnd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  nnd_pkg::result_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output nnd_pkg::result_type  pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   nnd_pkg::result_type slots_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_count_in_range, clock, reset, count_ff > CNT_W'(DEPTH))
   `ASSERT_PROP(a_count_grows, clock, reset, push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))

endmodule

// ----- rtl/nnd_back.sv -----
// Back end: output register that drains the queue onto the result channel.
// Uses nnd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  nnd_pkg::result_type  pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output nnd_pkg::result_type  rsp_data
);

   logic                rsp_valid_ff, rsp_valid_in;
   nnd_pkg::result_type rsp_data_ff;
   logic                load;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= pop_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_PROP(a_idle_output_loads, clock, reset, pop_valid && !rsp_valid_ff |=> rsp_valid_ff)

endmodule

// ----- rtl/nearest_neighbor_downscaler.sv -----
// Nearest neighbor image downscaler, top level: config registers, front end,
// result queue and output stage. Uses nnd_pkg, nnd_front, nnd_queue, nnd_back.
//
// Usage:
//   req_*  source RGBA pixels in raster order, valid/ready, one item per cycle.
//   rsp_*  selected pixels with destination column/row and a frame_end mark,
//          valid/ready. Source pixels that are not selected give no item.
//   csr_*  write-only registers (src/dst size, Q13.16 scale), written with
//          csr_we while the block is idle; no wait states.
// Throughput: one source pixel per cycle, sustained, as long as rsp_ready
// is high; the per-pixel work is three compares and a saturating add per axis.
// Path: a selected pixel is registered in a queue slot and then in the
// output register before it shows on rsp_valid.
// Stall: when rsp_ready is low the queue (QUEUE_DEPTH items) and the output
// register fill, then req_ready drops until the receiver takes an item.
// Reset: counters and targets go to the start of a frame, registers take
// src 1x1, dst width 1, dst height 0, scale 1.0; no item is in flight.
`timescale 1ns / 1ps

module nearest_neighbor_downscaler #(
   parameter int MAX_WIDTH   = nnd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = nnd_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS   = nnd_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = nnd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nnd_pkg::pixel_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nnd_pkg::result_type             rsp_data,
   input  logic                            csr_we,
   input  logic [nnd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nnd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   nnd_pkg::cfg_type    cfg_ff, cfg_in;
   logic                push_valid;
   logic                push_ready;
   nnd_pkg::result_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   nnd_pkg::result_type pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (nnd_pkg::csr_index_type'(csr_index))
            nnd_pkg::CSR_SRC_WIDTH: begin
               cfg_in.src_width = csr_wdata[nnd_pkg::CFG_DIM_W-1:0];
            end
            nnd_pkg::CSR_SRC_HEIGHT: begin
               cfg_in.src_height = csr_wdata[nnd_pkg::CFG_DIM_W-1:0];
            end
            nnd_pkg::CSR_DST_WIDTH: begin
               cfg_in.dst_width = csr_wdata[nnd_pkg::CFG_DIM_W-1:0];
            end
            nnd_pkg::CSR_DST_HEIGHT: begin
               cfg_in.dst_height = csr_wdata[nnd_pkg::CFG_DIM_W-1:0];
            end
            nnd_pkg::CSR_SCALE: begin
               cfg_in.scale_q16 = csr_wdata[nnd_pkg::SCALE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= nnd_pkg::CFG_DIM_W'(1);
         cfg_ff.src_height <= nnd_pkg::CFG_DIM_W'(1);
         cfg_ff.dst_width  <= nnd_pkg::CFG_DIM_W'(1);
         cfg_ff.dst_height <= '0;
         cfg_ff.scale_q16  <= nnd_pkg::SCALE_W'(1) << FRAC_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   nnd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   nnd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   nnd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
